// ----- sv/qtsd_pkg.sv -----
// qtsd_pkg: shared types and constants of the quantization table set decoder
// no dependencies; imported by the controller, the datapath and the checker
`default_nettype none

package qtsd_pkg;

    // field and register widths
    localparam int ENTRY_W   = 24;
    localparam int SCALE_W   = 17;
    localparam int PROD_W    = 25;
    localparam int RUN_W     = 32;
    localparam int POS_W     = 8;
    localparam int TSEL_W    = 3;
    localparam int ESEL_W    = 8;
    localparam int REQ_W     = 2;
    localparam int ERR_W     = 2;
    localparam int CTX_W     = 16;

    // table geometry: lower half stored, upper half mirrored on read
    localparam int HALF_ENTRIES = 128;
    localparam int HALF_BITS    = 7;

    // scale saturates one above the largest legal value
    localparam logic [SCALE_W-1:0] SCALE_SAT = 17'h10000;

    // request codes
    localparam logic [REQ_W-1:0] REQ_RUN   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FIRST_RUN = 2'd1;
    localparam logic [ERR_W-1:0] ERR_CONTEXT   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;       // latch the accepted input word
        logic clear_set;     // start a new table set
        logic set_err_first; // first run overflows the table
        logic run_setup;     // form the fill value and the write count
        logic fill_write;    // write one entry
        logic run_end;       // close the run, form the next scale
        logic scale_update;  // close the table
        logic rd_latch;      // take the memory read data
        logic load_out;      // load the result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             run_blocked;    // error pending or set already complete
        logic             first_too_long;
        logic             last_write;
        logic             table_full;
    } status_t;

endpackage

`default_nettype wire

// ----- sv/qtsd_ram.sv -----
// qtsd_ram: generic single port ram with registered read
// no dependencies
`default_nettype none

module qtsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 640
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read first port, read data registered every cycle
    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- sv/qtsd_ctrl.sv -----
// qtsd_ctrl: sequencing state machine of the table set decoder
// depends on qtsd_pkg (cmd_t, status_t, request codes)
`default_nettype none

module qtsd_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire qtsd_pkg::status_t status,
    output qtsd_pkg::cmd_t        cmd
);

    import qtsd_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_FILL     = 3'd2;
    localparam logic [2:0] S_RUN_END  = 3'd3;
    localparam logic [2:0] S_SCALE    = 3'd4;
    localparam logic [2:0] S_RD_DATA  = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = valid_reg;
    assign out_free = !valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (status.req)
                    REQ_RUN: begin
                        priority if (status.run_blocked) begin
                            state_next = S_FINISH;
                        end else if (status.first_too_long) begin
                            cmd.set_err_first = 1'b1;
                            state_next        = S_FINISH;
                        end else begin
                            cmd.run_setup = 1'b1;
                            state_next    = S_FILL;
                        end
                    end
                    REQ_READ: begin
                        state_next = S_RD_DATA;
                    end
                    REQ_START: begin
                        cmd.clear_set = 1'b1;
                        state_next    = S_FINISH;
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_FILL: begin
                cmd.fill_write = 1'b1;
                if (status.last_write) begin
                    state_next = S_RUN_END;
                end
            end
            S_RUN_END: begin
                cmd.run_end = 1'b1;
                state_next  = status.table_full ? S_SCALE : S_FINISH;
            end
            S_SCALE: begin
                cmd.scale_update = 1'b1;
                state_next       = S_FINISH;
            end
            S_RD_DATA: begin
                cmd.rd_latch = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid: set on load, cleared when taken
    always_comb begin
        valid_next = valid_reg;
        if (cmd.load_out) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/qtsd_dp.sv -----
// qtsd_dp: table set datapath: fill state, scale multiplier, table memory, result register
// depends on qtsd_pkg and qtsd_ram
`default_nettype none

module qtsd_dp #(
    parameter int NUM_TABLES   = 5,
    parameter int MAX_CONTEXTS = 32768
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire qtsd_pkg::cmd_t                cmd,
    output qtsd_pkg::status_t                  status,
    input  wire logic [qtsd_pkg::REQ_W-1:0]    s_req_type,
    input  wire logic [qtsd_pkg::RUN_W-1:0]    s_run_minus_one,
    input  wire logic [qtsd_pkg::TSEL_W-1:0]   s_table_sel,
    input  wire logic [qtsd_pkg::ESEL_W-1:0]   s_entry_sel,
    output logic signed [qtsd_pkg::ENTRY_W-1:0] m_entry_value,
    output logic [2:0]                         m_tables_done,
    output logic                               m_set_complete,
    output logic [qtsd_pkg::CTX_W-1:0]         m_context_total,
    output logic [qtsd_pkg::ERR_W-1:0]         m_error_code
);

    import qtsd_pkg::*;

    localparam int TBL_W  = $clog2(NUM_TABLES + 1);
    localparam int DEPTH  = NUM_TABLES * HALF_ENTRIES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [PROD_W-1:0] CTX_LIMIT = PROD_W'(2 * MAX_CONTEXTS - 1);
    localparam logic [TBL_W-1:0]  TBL_LAST  = TBL_W'(NUM_TABLES);

    // captured input word
    logic [REQ_W-1:0]   req_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [TSEL_W-1:0]  tsel_reg;
    logic [ESEL_W-1:0]  esel_reg;

    // set state
    logic [POS_W-1:0]   fill_reg, fill_next;
    logic [POS_W-1:0]   rc_reg, rc_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [TBL_W-1:0]   tcnt_reg, tcnt_next;
    logic [ERR_W-1:0]   err_reg, err_next;

    // run working registers
    logic [POS_W-1:0]   rem_reg;
    logic [ENTRY_W-1:0] stored_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ENTRY_W-1:0] value_reg;

    // result register
    logic [ENTRY_W-1:0] out_value_reg;
    logic [2:0]         out_tables_reg;
    logic               out_complete_reg;
    logic [CTX_W-1:0]   out_ctx_reg;
    logic [ERR_W-1:0]   out_err_reg;

    logic [POS_W-1:0]   remaining;
    logic               run_covers;
    logic [POS_W-1:0]   run_len;
    logic [POS_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic               complete;
    logic [SCALE_W-1:0] scale_inc;

    logic               rd_ok;
    logic               rd_neg;
    logic [HALF_BITS-1:0] rd_idx;
    logic [POS_W-1:0]   esel_neg;
    logic [ADDR_W-1:0]  wr_addr, rd_addr, ram_addr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] rd_value;

    // run length clipped at the end of the half table
    assign remaining  = POS_W'(HALF_ENTRIES) - fill_reg;
    assign run_covers = (|run_reg[RUN_W-1:POS_W]) || (run_reg[POS_W-1:0] >= remaining);
    assign run_len    = run_covers ? remaining : run_reg[POS_W-1:0] + POS_W'(1);

    // shared scale multiplier: fill value, then the next scale at table end
    assign mul_b = cmd.run_end ? {rc_reg[HALF_BITS-1:0], 1'b1} : rc_reg;
    assign mul_p = PROD_W'(scale_reg) * PROD_W'(mul_b);

    // status to the controller
    assign status.req            = req_reg;
    assign status.run_blocked    = (err_reg != ERR_NONE) || (tcnt_reg >= TBL_LAST);
    assign status.first_too_long = (fill_reg == '0) &&
                                   ((|run_reg[RUN_W-1:HALF_BITS]));
    assign status.last_write     = (rem_reg == POS_W'(1));
    assign status.table_full     = (fill_reg == POS_W'(HALF_ENTRIES));

    // mirrored read address: upper half reads the reflected lower entry
    assign esel_neg = POS_W'(0) - esel_reg;
    assign rd_neg   = esel_reg[HALF_BITS];
    always_comb begin
        priority if (!rd_neg) begin
            rd_idx = esel_reg[HALF_BITS-1:0];
        end else if (esel_reg == POS_W'(HALF_ENTRIES)) begin
            rd_idx = HALF_BITS'(HALF_ENTRIES - 1);
        end else begin
            rd_idx = esel_neg[HALF_BITS-1:0];
        end
    end
    assign rd_ok    = ({1'b0, tsel_reg} < (TSEL_W + 1)'(NUM_TABLES));
    assign rd_addr  = rd_ok ? ((ADDR_W'(tsel_reg) << HALF_BITS) | ADDR_W'(rd_idx)) : '0;
    assign wr_addr  = (ADDR_W'(tcnt_reg) << HALF_BITS) | ADDR_W'(fill_reg[HALF_BITS-1:0]);
    assign ram_addr = cmd.fill_write ? wr_addr : rd_addr;
    assign rd_value = !rd_ok ? '0 : (rd_neg ? ENTRY_W'(0) - ram_rdata : ram_rdata);

    qtsd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (cmd.fill_write),
        .addr  (ram_addr),
        .wdata (stored_reg),
        .rdata (ram_rdata)
    );

    // set state updates
    always_comb begin
        fill_next  = fill_reg;
        rc_next    = rc_reg;
        scale_next = scale_reg;
        tcnt_next  = tcnt_reg;
        err_next   = err_reg;
        if (cmd.clear_set) begin
            fill_next  = '0;
            rc_next    = '0;
            scale_next = SCALE_W'(1);
            tcnt_next  = '0;
            err_next   = ERR_NONE;
        end
        if (cmd.set_err_first) begin
            err_next = ERR_FIRST_RUN;
        end
        if (cmd.fill_write) begin
            fill_next = fill_reg + POS_W'(1);
        end
        if (cmd.run_end) begin
            rc_next = rc_reg + POS_W'(1);
        end
        if (cmd.scale_update) begin
            // overflow past the context bound: flag and saturate
            if (prod_reg > CTX_LIMIT) begin
                err_next   = ERR_CONTEXT;
                scale_next = (prod_reg > PROD_W'(SCALE_SAT)) ? SCALE_SAT
                                                             : prod_reg[SCALE_W-1:0];
            end else begin
                scale_next = prod_reg[SCALE_W-1:0];
            end
            tcnt_next = tcnt_reg + TBL_W'(1);
            fill_next = '0;
            rc_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            rc_reg    <= '0;
            scale_reg <= SCALE_W'(1);
            tcnt_reg  <= '0;
            err_reg   <= ERR_NONE;
        end else begin
            fill_reg  <= fill_next;
            rc_reg    <= rc_next;
            scale_reg <= scale_next;
            tcnt_reg  <= tcnt_next;
            err_reg   <= err_next;
        end
    end

    // input capture and run working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= s_req_type;
            run_reg   <= s_run_minus_one;
            tsel_reg  <= s_table_sel;
            esel_reg  <= s_entry_sel;
            value_reg <= '0;
        end
        if (cmd.run_setup) begin
            stored_reg <= mul_p[ENTRY_W-1:0];
            rem_reg    <= run_len;
        end
        if (cmd.fill_write) begin
            rem_reg <= rem_reg - POS_W'(1);
        end
        if (cmd.run_end) begin
            prod_reg <= mul_p;
        end
        if (cmd.rd_latch) begin
            value_reg <= rd_value;
        end
    end

    // result word from the state after the step
    assign complete  = (tcnt_reg >= TBL_LAST) && (err_reg == ERR_NONE);
    assign scale_inc = scale_reg + SCALE_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_value_reg    <= value_reg;
            out_tables_reg   <= 3'(tcnt_reg);
            out_complete_reg <= complete;
            out_ctx_reg      <= complete ? scale_inc[SCALE_W-1:1] : '0;
            out_err_reg      <= err_reg;
        end
    end

    assign m_entry_value   = $signed(out_value_reg);
    assign m_tables_done   = out_tables_reg;
    assign m_set_complete  = out_complete_reg;
    assign m_context_total = out_ctx_reg;
    assign m_error_code    = out_err_reg;

endmodule

`default_nettype wire

// ----- sv/quant_table_set_decode.sv -----
// quant_table_set_decode: top level of the quantization table set decoder
// depends on qtsd_pkg, qtsd_ctrl, qtsd_dp (which holds qtsd_ram)
//
// Usage:
//   Input channel (s_*): one word per request. req_type selects a run symbol,
//   a table entry read, or the start of a new table set. Every accepted word
//   produces exactly one result word on the m_* channel, in order.
//   Steps: a run symbol writes its len entries one per cycle through the
//     single table memory port, then closes the run, and closes the table
//     when the run fills it; an entry read is a registered memory read, then
//     sign mirror; a set start clears the set state; an ignored run or
//     another code only loads the result.
//   s_ready rises together with m_valid as each result is loaded, so a new
//   word is taken only once the previous one has reached the result register.
//   Reset (aresetn low, synchronous) empties the result register and starts a
//   fresh set: scale 1, no tables done, no error. The table memory is not
//   cleared; an entry must be written before it is read.
//   When the receiver stalls, the result word holds on m_* and the block may
//   take one more word, which it processes up to its result and then waits.
`default_nettype none

module quant_table_set_decode #(
    parameter int NUM_TABLES   = 5,
    parameter int MAX_CONTEXTS = 32768
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic [31:0]        s_run_minus_one,
    input  wire logic [2:0]         s_table_sel,
    input  wire logic [7:0]         s_entry_sel,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [23:0]      m_entry_value,
    output logic [2:0]              m_tables_done,
    output logic                    m_set_complete,
    output logic [15:0]             m_context_total,
    output logic [1:0]              m_error_code
);

    import qtsd_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    qtsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // state, memory and result word
    qtsd_dp #(
        .NUM_TABLES   (NUM_TABLES),
        .MAX_CONTEXTS (MAX_CONTEXTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_req_type      (s_req_type),
        .s_run_minus_one (s_run_minus_one),
        .s_table_sel     (s_table_sel),
        .s_entry_sel     (s_entry_sel),
        .m_entry_value   (m_entry_value),
        .m_tables_done   (m_tables_done),
        .m_set_complete  (m_set_complete),
        .m_context_total (m_context_total),
        .m_error_code    (m_error_code)
    );

endmodule

`default_nettype wire

// ----- sv/qtsd_checker.sv -----
// qtsd_checker: port level checks of the table set decoder result channel
// depends on qtsd_pkg; bound to quant_table_set_decode at the end of this file
`default_nettype none

module qtsd_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic signed [23:0]          m_entry_value,
    input  wire logic                        m_set_complete,
    input  wire logic [qtsd_pkg::CTX_W-1:0]  m_context_total,
    input  wire logic [qtsd_pkg::ERR_W-1:0]  m_error_code
);

    import qtsd_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_entry_value)
                                && $stable(m_error_code))
        else $error("stalled result word changed");

    // a complete set carries no error and at least one context
    a_complete_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_set_complete |-> m_error_code == ERR_NONE
                                      && m_context_total != '0)
        else $error("complete set with error or no contexts");

    // context count shows only on a complete set
    a_ctx_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_set_complete |-> m_context_total == '0)
        else $error("context count without complete set");

    // only the defined error codes appear
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_error_code == ERR_NONE || m_error_code == ERR_FIRST_RUN
                    || m_error_code == ERR_CONTEXT)
        else $error("undefined error code");

endmodule

bind quant_table_set_decode qtsd_checker u_qtsd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_entry_value   (m_entry_value),
    .m_set_complete  (m_set_complete),
    .m_context_total (m_context_total),
    .m_error_code    (m_error_code)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for the quantization table set decoder
// feeds run, read and set-start words with bursty valid and a stalling receiver
// depends on qtsd_pkg and quant_table_set_decode
`timescale 1ns / 1ps

module tb_top;
    import qtsd_pkg::*;

    localparam int N_TABLES    = 5;
    localparam int MAX_CTX     = 32768;
    localparam int STORE_SIZE  = N_TABLES * HALF_ENTRIES;
    localparam int RAND_WORDS  = 1400;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [RUN_W-1:0]  run_m1;
        logic [TSEL_W-1:0] tsel;
        logic [ESEL_W-1:0] esel;
    } sym_word_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] value;
        logic [2:0]         done;
        logic               complete;
        logic [CTX_W-1:0]   ctx;
        logic [ERR_W-1:0]   err;
    } set_status_t;

    typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE } rx_mode_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type = REQ_RUN;
    logic [31:0]        s_run_minus_one = '0;
    logic [2:0]         s_table_sel = '0;
    logic [7:0]         s_entry_sel = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [23:0] m_entry_value;
    logic [2:0]         m_tables_done;
    logic               m_set_complete;
    logic [15:0]        m_context_total;
    logic [1:0]         m_error_code;

    // words waiting to be sent, and the status words they will produce
    sym_word_t   symbol_q[$];
    set_status_t status_q[$];

    // shadow of the decoder state
    logic [ENTRY_W-1:0] shadow_tbl [STORE_SIZE];
    int unsigned        fill_pos;
    int unsigned        run_cnt;
    int unsigned        scale;
    int unsigned        tbl_cnt;
    logic [ERR_W-1:0]   err_flag;

    // bookkeeping
    int total_words;
    int sent_words;
    int acc_words;
    int rx_words;
    int fail_cnt;
    int n_runs, n_reads, n_starts;
    int sets_done, first_errs, ctx_errs;
    int unsigned peak_ctx;

    // driver, receiver and monitor locals
    sym_word_t   drv_word;
    int          burst_left;
    int          gap_left;
    rx_mode_t    rx_mode;
    int          rx_left;
    logic        rx_rdy;
    logic        hold_off = 1'b0;
    sym_word_t   mon_word;
    set_status_t mon_pred;
    set_status_t mon_want;

    quant_table_set_decode #(
        .NUM_TABLES   (N_TABLES),
        .MAX_CONTEXTS (MAX_CTX)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_run_minus_one (s_run_minus_one),
        .s_table_sel     (s_table_sel),
        .s_entry_sel     (s_entry_sel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_entry_value   (m_entry_value),
        .m_tables_done   (m_tables_done),
        .m_set_complete  (m_set_complete),
        .m_context_total (m_context_total),
        .m_error_code    (m_error_code)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // advance the shadow state by one word and form its status word
    task automatic table_set_step(input sym_word_t w, output set_status_t st);
        int unsigned remaining;
        int unsigned len;
        int unsigned prod;
        int unsigned base;
        int unsigned n;
        logic [ENTRY_W-1:0] fill;
        st = '0;
        case (w.req)
            REQ_RUN: begin
                if (err_flag == ERR_NONE && tbl_cnt < N_TABLES) begin
                    remaining = HALF_ENTRIES - fill_pos;
                    if (fill_pos == 0 && w.run_m1 >= remaining) begin
                        // first run of a table may not spill past its end
                        err_flag = ERR_FIRST_RUN;
                        first_errs++;
                    end else begin
                        len = (w.run_m1 >= remaining) ? remaining : w.run_m1 + 1;
                        fill = ENTRY_W'(scale * run_cnt);
                        for (n = 0; n < len; n++) begin
                            shadow_tbl[tbl_cnt * HALF_ENTRIES + fill_pos] = fill;
                            fill_pos++;
                        end
                        run_cnt++;
                        // table closed: fold its multiplier into the scale
                        if (fill_pos >= HALF_ENTRIES) begin
                            prod = scale * (2 * run_cnt - 1);
                            if (prod > 2 * MAX_CTX - 1) begin
                                err_flag = ERR_CONTEXT;
                                ctx_errs++;
                                if (prod > SCALE_SAT)
                                    prod = SCALE_SAT;
                            end
                            scale = prod;
                            tbl_cnt++;
                            fill_pos = 0;
                            run_cnt = 0;
                            if (tbl_cnt == N_TABLES && err_flag == ERR_NONE)
                                sets_done++;
                        end
                    end
                end
            end
            REQ_READ: begin
                // upper half is the negated mirror of the lower half
                if (w.tsel < N_TABLES) begin
                    base = w.tsel * HALF_ENTRIES;
                    if (w.esel < HALF_ENTRIES)
                        st.value = shadow_tbl[base + w.esel];
                    else if (w.esel == HALF_ENTRIES)
                        st.value = -shadow_tbl[base + HALF_ENTRIES - 1];
                    else
                        st.value = -shadow_tbl[base + 2 * HALF_ENTRIES - w.esel];
                end
            end
            REQ_START: begin
                fill_pos = 0;
                run_cnt  = 0;
                scale    = 1;
                tbl_cnt  = 0;
                err_flag = ERR_NONE;
            end
            default: begin
            end
        endcase
        st.complete = (tbl_cnt >= N_TABLES) && (err_flag == ERR_NONE);
        st.done     = 3'(tbl_cnt);
        st.ctx      = st.complete ? CTX_W'((scale + 1) / 2) : '0;
        st.err      = err_flag;
        if (st.ctx > peak_ctx)
            peak_ctx = st.ctx;
    endtask

    task automatic put_word(input logic [REQ_W-1:0] req, input logic [RUN_W-1:0] m1,
                            input logic [TSEL_W-1:0] tsel, input logic [ESEL_W-1:0] esel);
        sym_word_t w;
        w.req    = req;
        w.run_m1 = m1;
        w.tsel   = tsel;
        w.esel   = esel;
        symbol_q.insert(symbol_q.size(), w);
    endtask

    task automatic put_run(input logic [RUN_W-1:0] m1);
        put_word(REQ_RUN, m1, 3'($urandom), 8'($urandom));
    endtask

    task automatic put_read(input logic [TSEL_W-1:0] tsel, input logic [ESEL_W-1:0] esel);
        put_word(REQ_READ, $urandom, tsel, esel);
    endtask

    task automatic put_start();
        put_word(REQ_START, $urandom, 3'($urandom), 8'($urandom));
    endtask

    // stray words between runs: reads, the unused code, an odd run
    task automatic put_noise();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            put_read(3'($urandom_range(0, 7)), 8'($urandom));
        else if (pick < 9)
            put_word(REQ_UNUSED, $urandom, 3'($urandom), 8'($urandom));
        else
            put_run($urandom >> $urandom_range(0, 31));
    endtask

    // one table: k runs that together cover the lower half
    task automatic gen_table();
        int k, left, len, i, pick;
        logic [RUN_W-1:0] m1;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            k = $urandom_range(1, 3);
        else if (pick < 85)
            k = $urandom_range(4, 12);
        else if (pick < 96)
            k = $urandom_range(13, 60);
        else
            k = $urandom_range(61, HALF_ENTRIES);
        left = HALF_ENTRIES;
        for (i = 0; i < k; i++) begin
            if (i == k - 1)
                len = left;
            else
                len = $urandom_range(1, left - (k - 1 - i));
            m1 = RUN_W'(len - 1);
            if (i == 0 && $urandom_range(0, 39) == 0)
                m1 = RUN_W'(HALF_ENTRIES) + ($urandom >> $urandom_range(1, 31));
            else if (i > 0 && i == k - 1 && $urandom_range(0, 3) == 0)
                m1 = $urandom | m1;    // oversized last run gets clipped
            put_run(m1);
            left -= len;
            if ($urandom_range(0, 99) < 10)
                put_noise();
        end
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        fail_cnt++;
        $display("mismatch at result %0d: %s got %0d want %0d", rx_words, what, got, want);
    endtask

    // sender: bursts of words with random gaps in between
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && acc_words != sent_words)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (symbol_q.size() > 0) begin
                drv_word = symbol_q.pop_front();
                s_req_type      <= drv_word.req;
                s_run_minus_one <= drv_word.run_m1;
                s_table_sel     <= drv_word.tsel;
                s_entry_sel     <= drv_word.esel;
                s_valid         <= 1'b1;
                sent_words++;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: switches between stall patterns every so often
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 160);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   rx_rdy = 1'b1;
            RX_COIN:   rx_rdy = 1'($urandom_range(0, 1));
            RX_SPARSE: rx_rdy = ($urandom_range(0, 3) == 0);
            default:   rx_rdy = rx_left[2];
        endcase
        m_ready <= rx_rdy && !hold_off;
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (acc_words >= 300);
        @(negedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_off <= 1'b0;
    end

    // monitor: check each result word, then predict each accepted input word
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (status_q.size() == 0) begin
                    note_mismatch("result with nothing pending, entry_value", m_entry_value, 0);
                end else begin
                    mon_want = status_q.pop_front();
                    if (m_entry_value !== mon_want.value)
                        note_mismatch("entry_value", m_entry_value, $signed(mon_want.value));
                    if (m_tables_done !== mon_want.done)
                        note_mismatch("tables_done", m_tables_done, mon_want.done);
                    if (m_set_complete !== mon_want.complete)
                        note_mismatch("set_complete", m_set_complete, mon_want.complete);
                    if (m_context_total !== mon_want.ctx)
                        note_mismatch("context_total", m_context_total, mon_want.ctx);
                    if (m_error_code !== mon_want.err)
                        note_mismatch("error_code", m_error_code, mon_want.err);
                end
                rx_words++;
            end
            if (s_valid && s_ready) begin
                mon_word = {s_req_type, s_run_minus_one, s_table_sel, s_entry_sel};
                table_set_step(mon_word, mon_pred);
                status_q.insert(status_q.size(), mon_pred);
                acc_words++;
                case (mon_word.req)
                    REQ_RUN:   n_runs++;
                    REQ_READ:  n_reads++;
                    REQ_START: n_starts++;
                    default:   begin end
                endcase
            end
        end
    end

    // run limit
    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int ntab;
        fill_pos = 0;
        run_cnt  = 0;
        scale    = 1;
        tbl_cnt  = 0;
        err_flag = ERR_NONE;
        rx_left  = 0;
        burst_left = 0;
        gap_left   = 0;

        // first run too long right after reset, then a run ignored after the error
        put_run(RUN_W'(HALF_ENTRIES));
        put_run('0);
        put_start();
        // a full set that writes every entry: multipliers 3 and 3, the rest 1
        put_run('0);
        put_run(RUN_W'(126));
        put_run(RUN_W'(63));
        put_run('1);
        put_run(RUN_W'(127));
        put_run(RUN_W'(127));
        put_run(RUN_W'(127));
        // run after completion is ignored
        put_run(RUN_W'(5));
        // reads across both halves and out-of-range tables
        put_read(3'd0, 8'd0);
        put_read(3'd0, 8'd1);
        put_read(3'd0, 8'd128);
        put_read(3'd1, 8'd127);
        put_read(3'd1, 8'd128);
        put_read(3'd1, 8'd129);
        put_read(3'd1, 8'd255);
        put_read(3'd4, 8'd200);
        put_read(3'd5, 8'd0);
        put_read(3'd7, 8'd255);
        put_word(REQ_UNUSED, '1, 3'd7, 8'hff);

        // random sets: mostly well formed, some cut short or left unstarted
        while (symbol_q.size() < RAND_WORDS) begin
            if ($urandom_range(0, 19) != 0)
                put_start();
            ntab = ($urandom_range(0, 9) == 0) ? $urandom_range(1, N_TABLES - 1) : N_TABLES;
            repeat (ntab) gen_table();
            if ($urandom_range(0, 9) == 0)
                put_run($urandom);
            repeat ($urandom_range(1, 4)) put_read(3'($urandom_range(0, 7)), 8'($urandom));
        end
        total_words = symbol_q.size();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (acc_words == total_words);
        wait (status_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d words: %0d runs, %0d reads, %0d set starts",
                 acc_words, n_runs, n_reads, n_starts);
        $display("sets completed %0d, first-run errors %0d, context errors %0d, peak context %0d",
                 sets_done, first_errs, ctx_errs, peak_ctx);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
